// File: hdl/minv_pkg.sv
// minv_pkg: types, constants and fixed-point helpers for the 4x4 matrix inverse unit
// no dependencies; used by matrix_inverse_4x4_unit
`timescale 1ns / 1ps
`default_nettype none

package minv_pkg;

	localparam int ELEMENT_BITS  = 32;
	localparam int FRACTION_BITS = 16;
	localparam int PROD_BITS     = 2 * ELEMENT_BITS;
	localparam int NUM_BITS      = ELEMENT_BITS + FRACTION_BITS;
	localparam int ACC_BITS      = ELEMENT_BITS + 4;
	localparam int DIV_STEPS     = NUM_BITS;
	localparam int BIT_CNT_BITS  = $clog2(DIV_STEPS);

	localparam logic [ELEMENT_BITS-1:0] POS_LIMIT = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MAX =
		{{(ACC_BITS-ELEMENT_BITS+1){1'b0}}, {(ELEMENT_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN =
		{{(ACC_BITS-ELEMENT_BITS+1){1'b1}}, {(ELEMENT_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [ELEMENT_BITS-1:0] element_value;
		logic [3:0]                     element_position;
		logic                           load_done;
	} elem_t;

	typedef struct packed {
		logic signed [ELEMENT_BITS-1:0] result_value;
		logic [3:0]                     result_position;
		logic                           singular;
		logic                           final_result;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADJ,
		S_DET,
		S_DIV_LD,
		S_DIV,
		S_SING_RD,
		S_EMIT
	} state_t;

	// k-th of the three indexes 0..3 that are not skip
	function automatic logic [1:0] other_idx(input logic [1:0] skip, input logic [1:0] k);
		other_idx = (k < skip) ? k : 2'(k + 2'd1);
	endfunction

	// column permutation for one of the six cofactor terms
	function automatic logic [1:0] perm_col(input logic [2:0] term, input logic [1:0] k);
		logic [5:0] row;
		case (term)
			3'd0:    row = {2'd0, 2'd1, 2'd2};
			3'd1:    row = {2'd0, 2'd2, 2'd1};
			3'd2:    row = {2'd1, 2'd0, 2'd2};
			3'd3:    row = {2'd1, 2'd2, 2'd0};
			3'd4:    row = {2'd2, 2'd0, 2'd1};
			default: row = {2'd2, 2'd1, 2'd0};
		endcase
		case (k)
			2'd0:    perm_col = row[5:4];
			2'd1:    perm_col = row[3:2];
			default: perm_col = row[1:0];
		endcase
	endfunction

	function automatic logic perm_sub(input logic [2:0] term);
		perm_sub = (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
	endfunction

	function automatic logic [ELEMENT_BITS-1:0] mag(input logic signed [ELEMENT_BITS-1:0] v);
		mag = v[ELEMENT_BITS-1] ? ELEMENT_BITS'(-v) : ELEMENT_BITS'(v);
	endfunction

	// saturate a magnitude to a signed element
	function automatic logic signed [ELEMENT_BITS-1:0] sat_mag(input logic [PROD_BITS-1:0] m,
			input logic neg);
		logic [ELEMENT_BITS-1:0] lim;
		logic [ELEMENT_BITS-1:0] v;
		lim = neg ? ELEMENT_BITS'(POS_LIMIT + 1'b1) : POS_LIMIT;
		v = (m > PROD_BITS'(lim)) ? lim : m[ELEMENT_BITS-1:0];
		sat_mag = neg ? ELEMENT_BITS'(-v) : v;
	endfunction

	function automatic logic signed [ELEMENT_BITS-1:0] clamp_acc(
			input logic signed [ACC_BITS-1:0] v);
		if (v > ACC_MAX)
			clamp_acc = ACC_MAX[ELEMENT_BITS-1:0];
		else if (v < ACC_MIN)
			clamp_acc = ACC_MIN[ELEMENT_BITS-1:0];
		else
			clamp_acc = v[ELEMENT_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/matrix_inverse_4x4_unit.sv
// sequence: after the request marked load_done, the unit forms the cofactor terms on one
// shared multiplier, then the determinant, then runs a bit-serial divide for each result;
// when singular it returns each stored element without a divide
// throughput: loading takes one cycle per element; the unit stalls while inverting
// reset: asynchronous active-low arst_n clears the sequencer and output valid;
// the matrix store is undefined until written
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_4x4_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  element_valid,
	output logic                 element_stall,
	input  minv_pkg::elem_t      element,
	output logic                 result_valid,
	input  wire                  result_stall,
	output minv_pkg::result_t    result
);
	import minv_pkg::*;

	state_t state_q, state_d;

	logic [3:0]                    idx_q;
	logic [2:0]                    term_q;
	logic [2:0]                    ph_q;
	logic [BIT_CNT_BITS-1:0]       bit_q;
	logic signed [ELEMENT_BITS-1:0] mem_q [16];
	logic signed [ELEMENT_BITS-1:0] rd_q;
	logic [3:0]                    raddr;
	logic signed [ELEMENT_BITS-1:0] a_q, b_q, c_q;
	logic [PROD_BITS-1:0]          prod_q;
	logic                          pneg_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [ELEMENT_BITS-1:0] adj_q [16];
	logic [3:0]                    adj_addr;
	logic signed [ELEMENT_BITS-1:0] adj_rd;
	logic                          det_neg_q;
	logic [ELEMENT_BITS-1:0]       den_q;
	logic                          sing_q;
	logic [NUM_BITS-1:0]           num_q;
	logic [ELEMENT_BITS-1:0]       rem_q;
	logic [NUM_BITS-1:0]           quo_q;
	logic                          qneg_q;
	logic                          out_valid_q;
	result_t                       out_q;

	logic                          in_fire;
	logic                          out_free;
	logic                          emit_load;
	logic [1:0]                    kk;
	logic [3:0]                    adj_src;
	logic signed [ELEMENT_BITS-1:0] term_f;
	logic                          term_neg;
	logic signed [ACC_BITS-1:0]    acc_base;
	logic signed [ACC_BITS-1:0]    acc_sum;
	logic signed [ELEMENT_BITS-1:0] det_d;
	logic [ELEMENT_BITS:0]         r2;
	logic                          ge;
	logic [ELEMENT_BITS:0]         r2_sub;

	assign element_stall = (state_q != S_IDLE);
	assign in_fire       = element_valid && !element_stall;
	assign out_free      = !out_valid_q || !result_stall;
	assign emit_load     = (state_q == S_EMIT) && out_free;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

	// operand address of the cofactor term: row skips c, column skips r
	assign kk      = (ph_q > 3'd2) ? 2'd0 : ph_q[1:0];
	assign adj_src = {other_idx(idx_q[1:0], kk), other_idx(idx_q[3:2], perm_col(term_q, kk))};

	always_comb begin
		unique case (state_q)
			S_ADJ:   raddr = adj_src;
			S_DET:   raddr = {2'b00, term_q[1:0]};
			default: raddr = idx_q;
		endcase
	end

	assign adj_addr = (state_q == S_DET) ? {term_q[1:0], 2'b00} : idx_q;
	assign adj_rd   = adj_q[adj_addr];

	assign term_f   = sat_mag(PROD_BITS'(prod_q >> FRACTION_BITS), pneg_q);
	assign term_neg = (state_q == S_ADJ) && perm_sub(term_q);
	assign acc_base = (term_q == 3'd0) ? '0 : acc_q;
	assign acc_sum  = term_neg ? (acc_base - ACC_BITS'(term_f)) : (acc_base + ACC_BITS'(term_f));
	assign det_d    = clamp_acc(acc_sum);

	assign r2     = {rem_q, num_q[NUM_BITS-1]};
	assign ge     = (r2 >= {1'b0, den_q});
	assign r2_sub = r2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && element.load_done)
					state_d = S_ADJ;
			end
			S_ADJ: begin
				if (ph_q == 3'd6 && term_q == 3'd5 && idx_q == 4'd15)
					state_d = S_DET;
			end
			S_DET: begin
				if (ph_q == 3'd3 && term_q == 3'd3)
					state_d = (det_d == '0) ? S_SING_RD : S_DIV_LD;
			end
			S_DIV_LD: state_d = S_DIV;
			S_DIV: begin
				if (bit_q == BIT_CNT_BITS'(DIV_STEPS - 1))
					state_d = S_EMIT;
			end
			S_SING_RD: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					if (idx_q == 4'd15)
						state_d = S_IDLE;
					else
						state_d = sing_q ? S_SING_RD : S_DIV_LD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			term_q      <= '0;
			ph_q        <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q  <= '0;
					term_q <= '0;
					ph_q   <= '0;
				end
				S_ADJ: begin
					if (ph_q == 3'd6) begin
						ph_q <= '0;
						if (term_q == 3'd5) begin
							term_q <= '0;
							idx_q  <= idx_q + 4'd1;
						end else begin
							term_q <= term_q + 3'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_DET: begin
					if (ph_q == 3'd3) begin
						ph_q   <= '0;
						term_q <= (term_q == 3'd3) ? 3'd0 : term_q + 3'd1;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_DIV_LD: bit_q <= '0;
				S_DIV:    bit_q <= bit_q + 1'b1;
				S_EMIT: begin
					if (out_free)
						idx_q <= idx_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			mem_q[element.element_position] <= element.element_value;
		rd_q <= mem_q[raddr];
	end

	// shared multiplier, one product per cycle from the operand registers
	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(mag(a_q)) * PROD_BITS'(mag(b_q));
		pneg_q <= a_q[ELEMENT_BITS-1] ^ b_q[ELEMENT_BITS-1];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_ADJ: begin
				case (ph_q)
					3'd1: a_q <= rd_q;
					3'd2: b_q <= rd_q;
					3'd3: c_q <= rd_q;
					3'd4: begin
						a_q <= term_f;
						b_q <= c_q;
					end
					3'd6: begin
						acc_q <= acc_sum;
						if (term_q == 3'd5)
							adj_q[idx_q] <= clamp_acc((idx_q[2] ^ idx_q[0]) ? -acc_sum : acc_sum);
					end
					default: ;
				endcase
			end
			S_DET: begin
				if (ph_q == 3'd1) begin
					a_q <= rd_q;
					b_q <= adj_rd;
				end
				if (ph_q == 3'd3) begin
					acc_q <= acc_sum;
					if (term_q == 3'd3) begin
						sing_q    <= (det_d == '0);
						den_q     <= mag(det_d);
						det_neg_q <= det_d[ELEMENT_BITS-1];
					end
				end
			end
			S_DIV_LD: begin
				num_q  <= {mag(adj_rd), {FRACTION_BITS{1'b0}}};
				rem_q  <= '0;
				quo_q  <= '0;
				qneg_q <= adj_rd[ELEMENT_BITS-1] ^ det_neg_q;
			end
			S_DIV: begin
				rem_q <= ge ? r2_sub[ELEMENT_BITS-1:0] : r2[ELEMENT_BITS-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[NUM_BITS-2:0], ge};
			end
			default: ;
		endcase
		if (emit_load) begin
			out_q.result_value    <= sing_q ? rd_q : sat_mag(PROD_BITS'(quo_q), qneg_q);
			out_q.result_position <= idx_q;
			out_q.singular        <= sing_q;
			out_q.final_result    <= (idx_q == 4'd15);
		end
	end

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && element.load_done |=> element_stall)
		else $error("unit not busy after last element");
	a_nonfinal_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.final_result |-> state_q != S_IDLE)
		else $error("sequencer idle with results outstanding");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q != '0 && !sing_q)
		else $error("divide started on zero determinant");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && !out_free |=> state_q == S_EMIT && $stable(idx_q))
		else $error("result lost under stall");
`endif

endmodule

`default_nettype wire

// File: bench/tb_matrix_inverse_4x4_unit.sv
// self-checking bench for matrix_inverse_4x4_unit: loads random and directed matrices,
// predicts the adjugate inverse in Q16.16 and compares every result element
// depends on minv_pkg and matrix_inverse_4x4_unit
`timescale 1ns / 1ps

class inverse_scoreboard;
	logic signed [31:0] store [16];
	minv_pkg::result_t pending [$];
	int errors;

	function new();
		errors = 0;
		for (int i = 0; i < 16; i++) store[i] = '0;
	endfunction

	function automatic logic [63:0] mag64(input longint v);
		mag64 = v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint sat_signed(input logic [63:0] m, input bit neg);
		logic [63:0] lim;
		lim = neg ? 64'h80000000 : 64'h7fffffff;
		if (m > lim) m = lim;
		sat_signed = neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sh7fffffff) clamp32 = 64'sh7fffffff;
		else if (v < -64'sh80000000) clamp32 = -64'sh80000000;
		else clamp32 = v;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		logic [127:0] p;
		logic [127:0] q;
		p = 128'(mag64(a)) * 128'(mag64(b));
		q = p >> 16;
		fx_mul = sat_signed(q[127:64] != 0 ? 64'hffffffffffffffff : q[63:0],
			(a < 0) != (b < 0));
	endfunction

	function automatic longint fx_div(input longint n, input longint d);
		logic [127:0] q;
		q = (128'(mag64(n)) << 16) / 128'(mag64(d));
		fx_div = sat_signed(q[127:64] != 0 ? 64'hffffffffffffffff : q[63:0],
			(n < 0) != (d < 0));
	endfunction

	function automatic longint cofactor(input int r, input int c);
		int rows [3];
		int cols [3];
		int perm [6][4];
		int n;
		int m;
		longint sum;
		longint p;
		perm = '{'{0,1,2,0}, '{0,2,1,1}, '{1,0,2,1}, '{1,2,0,0}, '{2,0,1,0}, '{2,1,0,1}};
		n = 0;
		m = 0;
		sum = 0;
		for (int k = 0; k < 4; k++) begin
			if (k != c) begin
				rows[n] = k;
				n = n + 1;
			end
			if (k != r) begin
				cols[m] = k;
				m = m + 1;
			end
		end
		for (int k = 0; k < 6; k++) begin
			p = fx_mul(store[rows[0]*4 + cols[perm[k][0]]], store[rows[1]*4 + cols[perm[k][1]]]);
			p = fx_mul(p, store[rows[2]*4 + cols[perm[k][2]]]);
			sum += perm[k][3] ? -p : p;
		end
		if ((r + c) % 2) sum = -sum;
		cofactor = clamp32(sum);
	endfunction

	function void note_request(input minv_pkg::elem_t e);
		longint adj [16];
		longint det;
		bit sing;
		minv_pkg::result_t r;
		store[e.element_position] = e.element_value;
		if (!e.load_done) return;
		det = 0;
		for (int i = 0; i < 16; i++) adj[i] = cofactor(i / 4, i % 4);
		for (int i = 0; i < 4; i++) det += fx_mul(store[i], adj[i*4]);
		det = clamp32(det);
		sing = det == 0;
		for (int i = 0; i < 16; i++) begin
			r.result_value = sing ? store[i] : 32'(fx_div(adj[i], det));
			r.result_position = 4'(i);
			r.singular = sing;
			r.final_result = i == 15;
			pending.push_back(r);
		end
	endfunction

	function void check_result(input minv_pkg::result_t got);
		minv_pkg::result_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result got %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			$display("%0t: mismatch expected val=%h pos=%0d sing=%b fin=%b actual val=%h pos=%0d sing=%b fin=%b",
				$time, want.result_value, want.result_position, want.singular,
				want.final_result, got.result_value, got.result_position, got.singular,
				got.final_result);
			errors++;
		end
	endfunction
endclass

module tb_matrix_inverse_4x4_unit;
	import minv_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic element_valid = 0;
	logic element_stall;
	elem_t element = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;
	bit calm = 0;
	bit done_driving = 0;
	inverse_scoreboard sb = new();

	matrix_inverse_4x4_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.element_valid(element_valid), .element_stall(element_stall), .element(element),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #10 clk = ~clk;

	// sample at rising edge
	always @(posedge clk) begin
		if (arst_n && element_valid && !element_stall) sb.note_request(element);
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (!calm && $urandom_range(0, 5) == 0) begin
			result_stall <= 1;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		result_stall <= 0;
	end

	// valid stays high between back-to-back requests
	task automatic send(input logic signed [31:0] v, input int pos, input bit last);
		if (!calm && $urandom_range(0, 5) == 0) begin
			element_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		element_valid <= 1;
		element <= '{v, 4'(pos), last};
		@(posedge clk);
		while (element_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: rand_elem = $urandom;
			1: rand_elem = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: rand_elem = 0;
			default: rand_elem = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		endcase
	endfunction

	// full matrix; loads every position in random order, last one marked
	task automatic load_matrix(input int kind);
		int order [16];
		logic signed [31:0] v;
		for (int i = 0; i < 16; i++) order[i] = i;
		order.shuffle();
		for (int i = 0; i < 16; i++) begin
			case (kind)
				0: v = (order[i] % 5 == 0) ? 32'sh10000 : 0;
				1: v = 0;
				2: v = 32'sh7fffffff;
				3: v = 32'sh80000000;
				default: v = rand_elem();
			endcase
			send(v, order[i], i == 15);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		load_matrix(0);     // identity
		load_matrix(1);     // zero, singular
		send(32'sh20000, 5, 1);   // repeated position then reinvert
		load_matrix(2);
		load_matrix(3);
		for (int m = 0; m < 12; m++) begin
			if (m == 9) calm = 1;
			if ($urandom_range(0, 2) == 0) begin
				// partial update on a filled store
				repeat ($urandom_range(1, 5)) send(rand_elem(), $urandom_range(0, 15), 0);
				send(rand_elem(), $urandom_range(0, 15), 1);
			end else
				load_matrix(4);
		end
		element_valid <= 0;
		done_driving = 1;
	end

	initial begin
		wait (done_driving);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
